/* design/mhos_pkg.sv */
package mhos_pkg;

	localparam int DefCapacity = 64;
	localparam int KeyW = 32;
	localparam int ScoreW = 16;
	localparam int PayW = 32;
	localparam int CountW = 7;
	localparam int EntryW = KeyW + ScoreW + PayW;

	typedef enum logic [1:0] {
		FN_PUSH   = 2'd0,
		FN_POP    = 2'd1,
		FN_UPDATE = 2'd2,
		FN_FIND   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef struct packed {
		logic [KeyW-1:0]   key;
		logic [ScoreW-1:0] score;
		logic [PayW-1:0]   payload;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_CHK,
		S_UP_RD,
		S_UP_CMP,
		S_POP_RD,
		S_POP_LAST,
		S_POP_MOVE,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_CMP,
		S_WRB,
		S_DONE
	} state_t;

	// memory port enables from the sequencer to the entry store
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

/* design/mhos_store.sv */
// Entry store: one write port, one registered read port.
module mhos_store
	import mhos_pkg::*;
#(
	parameter int CAPACITY = DefCapacity,
	parameter int AW = $clog2(CAPACITY)
) (
	input  logic           clk,
	input  mem_ctl_t       ctl,
	input  logic [AW-1:0]  rd_addr,
	output entry_t         rd_data,
	input  logic [AW-1:0]  wr_addr,
	input  entry_t         wr_data
);

	entry_t mem [CAPACITY];

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/min_heap_open_set.sv */
// Push/update sift up with a parent read and a compare per level; pop sifts
// down with a left-child read, a right-child read and a compare per level;
// update and find first scan keys, reading and checking one slot at a time.
// One request at a time; s_tready is low while
// busy and while a result waits, and returns the cycle after the result leaves.
// Reset clears the count, control and result register; entry memory is not cleared.
module min_heap_open_set
	import mhos_pkg::*;
#(
	parameter int CAPACITY = DefCapacity
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [87:0]  s_tdata,  // in_key[31:0], in_score[47:32], in_payload[79:48]
	input  logic [1:0]   s_tuser,  // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata,  // out_key, out_score, out_payload, entry_count[86:80]
	output logic [1:0]   m_tuser   // status
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_nx;
	func_t func_q;
	entry_t req_q;         // request fields, later the moving entry
	entry_t oth_q;         // left child read
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pos_q;  // current slot (CW wide so it can reach count)
	logic [CW:0] lc_w, rc_w;
	logic lc_in_w, rc_in_w;
	logic lc_ok_q, rc_ok_q;
	logic acc;

	mem_ctl_t ctl;
	logic [AW-1:0] rd_addr, wr_addr;
	entry_t rd_data, wr_data;

	logic out_full_q;
	status_t out_st_q;
	entry_t out_e_q;
	logic [CountW-1:0] out_cnt_q;

	logic [CW-1:0] parent_w;
	assign parent_w = (pos_q - CW'(1)) >> 1;
	assign lc_w = {pos_q, 1'b1};
	assign rc_w = {pos_q, 1'b0} + (CW+1)'(2);
	assign lc_in_w = lc_w < (CW+1)'(cnt_q);
	assign rc_in_w = rc_w < (CW+1)'(cnt_q);

	mhos_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
		.clk(clk), .ctl(ctl), .rd_addr(rd_addr), .rd_data(rd_data),
		.wr_addr(wr_addr), .wr_data(wr_data)
	);

	assign s_tready = (state_q == S_IDLE) && !out_full_q;
	assign acc = s_tvalid && s_tready;

	// down-step choice: left if strictly smaller, right if smaller than that
	// (right child data sits on the read port during S_DN_CMP)
	logic take_l, take_r;
	logic [ScoreW-1:0] best_sc;
	always_comb begin
		take_l = lc_ok_q && (oth_q.score < req_q.score);
		best_sc = take_l ? oth_q.score : req_q.score;
		take_r = rc_ok_q && (rd_data.score < best_sc);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (acc) begin
				unique case (func_t'(s_tuser))
					FN_PUSH:  state_nx = (cnt_q >= CW'(CAPACITY)) ? S_DONE : S_UP_RD;
					FN_POP:   state_nx = (cnt_q == '0) ? S_DONE : S_POP_RD;
					default:  state_nx = (cnt_q == '0) ? S_DONE : S_SCAN;
				endcase
			end
			S_SCAN:     state_nx = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (rd_data.key == req_q.key)
					state_nx = (func_q == FN_FIND) ? S_DONE : S_UP_RD;
				else if (pos_q + CW'(1) >= cnt_q) state_nx = S_DONE;
				else state_nx = S_SCAN;
			end
			S_UP_RD:    state_nx = (pos_q == '0) ? S_WRB : S_UP_CMP;
			S_UP_CMP:   state_nx = (rd_data.score > req_q.score) ? S_UP_RD : S_WRB;
			S_POP_RD:   state_nx = S_POP_LAST;
			S_POP_LAST: state_nx = S_POP_MOVE;
			S_POP_MOVE: state_nx = (cnt_q == '0) ? S_DONE : S_DN_RDL;
			S_DN_RDL:   state_nx = S_DN_RDR;
			S_DN_RDR:   state_nx = S_DN_CMP;
			S_DN_CMP:   state_nx = (take_l || take_r) ? S_DN_RDL : S_WRB;
			S_WRB:      state_nx = S_DONE;
			S_DONE:     state_nx = S_IDLE;
			default:    state_nx = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		ctl = '0;
		rd_addr = pos_q[AW-1:0];
		wr_addr = pos_q[AW-1:0];
		wr_data = req_q;
		unique case (state_q)
			S_SCAN:   ctl.rd_en = 1'b1;
			S_UP_RD:  begin ctl.rd_en = 1'b1; rd_addr = parent_w[AW-1:0]; end
			S_UP_CMP: if (rd_data.score > req_q.score) begin
				ctl.wr_en = 1'b1; wr_data = rd_data;
			end
			S_POP_RD: begin ctl.rd_en = 1'b1; rd_addr = '0; end
			S_POP_LAST: begin ctl.rd_en = 1'b1; rd_addr = AW'(cnt_q - CW'(1)); end
			S_DN_RDL: begin ctl.rd_en = lc_in_w; rd_addr = lc_w[AW-1:0]; end
			S_DN_RDR: begin ctl.rd_en = rc_in_w; rd_addr = rc_w[AW-1:0]; end
			S_DN_CMP: if (take_l || take_r) begin
				ctl.wr_en = 1'b1; wr_data = take_r ? rd_data : oth_q;
			end
			S_WRB:    ctl.wr_en = 1'b1;
			default:  ;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q <= FN_PUSH;
			req_q <= '0;
			oth_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
			lc_ok_q <= 1'b0;
			rc_ok_q <= 1'b0;
			out_full_q <= 1'b0;
			out_st_q <= ST_OK;
			out_e_q <= '0;
			out_cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				S_IDLE: begin
					if (m_tvalid && m_tready) out_full_q <= 1'b0;
					if (acc) begin
						func_q <= func_t'(s_tuser);
						req_q <= {s_tdata[31:0], s_tdata[47:32], s_tdata[79:48]};
						out_e_q <= '0;
						out_st_q <= ST_OK;
						pos_q <= '0;
						unique case (func_t'(s_tuser))
							FN_PUSH: if (cnt_q >= CW'(CAPACITY)) out_st_q <= ST_FULL;
								else begin pos_q <= cnt_q; cnt_q <= cnt_q + CW'(1); end
							FN_POP: if (cnt_q == '0) out_st_q <= ST_EMPTY;
							default: if (cnt_q == '0) out_st_q <= ST_MISSING;
						endcase
					end
				end
				// key compare; update keeps the matching slot in pos_q
				S_SCAN_CHK: begin
					if (rd_data.key == req_q.key) begin
						if (func_q == FN_FIND) out_e_q <= rd_data;
					end else if (pos_q + CW'(1) >= cnt_q) out_st_q <= ST_MISSING;
					else pos_q <= pos_q + CW'(1);
				end
				S_UP_CMP: if (rd_data.score > req_q.score) pos_q <= parent_w;
				// pop: root captured, last entry becomes the moving entry
				S_POP_LAST: begin
					out_e_q <= rd_data;
					cnt_q <= cnt_q - CW'(1);
				end
				S_POP_MOVE: begin
					req_q <= rd_data;
					pos_q <= '0;
				end
				S_DN_RDR: begin
					oth_q <= rd_data;
					lc_ok_q <= lc_in_w;
					rc_ok_q <= rc_in_w;
				end
				S_DN_CMP: begin
					if (take_r) pos_q <= rc_w[CW-1:0];
					else if (take_l) pos_q <= lc_w[CW-1:0];
				end
				S_DONE: begin
					out_full_q <= 1'b1;
					out_cnt_q <= CountW'(cnt_q);
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_full_q;
	assign m_tuser = out_st_q;
	assign m_tdata = {1'b0, out_cnt_q, out_e_q.payload, out_e_q.score, out_e_q.key};

	// at most CAPACITY entries held
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY)) else $error("count overflow");
	// a result only appears after the sequencer finished
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_full_q) |-> $past(state_q) == S_DONE) else $error("stray result");
	// not ready while a request is in progress
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !s_tready) else $error("ready while busy");
	// a waiting result holds steady
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while waiting");

endmodule
